[sv/mts_pkg.sv]
// Package for the memory test sequencer: sequencer phases, access kinds,
// configuration register indexes and default sizes.
// No dependencies; used by memory_test_sequencer.
package mts_pkg;

    // Default sizes for the top level parameters.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ADDR_WIDTH_DEF = 16;

    // Fixed widths of the transaction fields and configuration registers.
    localparam int FIELD_W     = 32;
    localparam int REGION_W    = 17;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_WORDS = 1'd1;

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // Test modes carried by a start transaction.
    localparam logic [1:0] MODE_DATA_BUS = 2'd0;
    localparam logic [1:0] MODE_ADDR_BUS = 2'd1;
    localparam logic [1:0] MODE_DEVICE   = 2'd2;

    // Access kinds on the result channel.
    localparam logic [1:0] KIND_IDLE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // Pattern used by the address bus test.
    localparam logic [FIELD_W-1:0] AB_PATTERN = 32'hAAAA_AAAA;

    // Sequencer phases: each names the access that was just issued.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DB_WROTE,
        PH_DB_READ,
        PH_AB_FILL,
        PH_AB_BASE_ANTI,
        PH_AB_CHECK,
        PH_AB_BASE_PAT,
        PH_AB_VICTIM_ANTI,
        PH_AB_SCAN,
        PH_AB_VICTIM_RESTORE,
        PH_DV_FILL,
        PH_DV_CHECK,
        PH_DV_CLEAR
    } phase_t;

endpackage

[sv/memory_test_sequencer.sv]
// Memory test sequencer top level: phase register, test datapath and result register.
// Depends on mts_pkg.
//
// The sequencer drives an external word-addressed memory in lockstep with its user.
// A transaction on the s_ channel with s_func low starts a test chosen by s_test_mode:
// a walking-ones data bus test on the base word, an address bus test that writes a
// pattern at word offsets 1, 2, 4 and so on and checks for aliasing, or a device test
// that fills the region with an incrementing pattern, then reads back and clears it.
// A transaction with s_func high is a step and carries, in s_read_data, the data of
// the previous read. Every input transaction yields exactly one result transaction on
// the m_ channel: the next write or read access, an idle answer, or a done report that
// gives pass or fail and the failing word address.
// The region is set through the cfg_ channel (index 0 base word address, index 1 the
// number of words); writes are taken at any time and always acknowledged.
// The result of a transaction is registered: it is shown on the m_ channel right after
// the edge that accepts it. Throughput is one transaction per cycle while the m_ side
// takes its results, bounded by the single phase register that each step reads
// and updates.
// The result register frees up in the same cycle that its transaction is taken, so
// s_ready only falls while a result waits and m_ready is low; no result is dropped.
// Reset clears the phase to idle, empties the result register and restores the
// region to base 0 and 65536 words.
module memory_test_sequencer #(
    parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_WIDTH = mts_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mts_pkg::FIELD_W-1:0]       cfg_wdata,
    // Input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [1:0]                        s_test_mode,
    input  logic [mts_pkg::FIELD_W-1:0]       s_read_data,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_access_kind,
    output logic [mts_pkg::FIELD_W-1:0]       m_access_address,
    output logic [mts_pkg::FIELD_W-1:0]       m_write_data,
    output logic                              m_test_passed,
    output logic [mts_pkg::FIELD_W-1:0]       m_fail_address
);

    import mts_pkg::*;

    // Patterns and compares use at most the 32 bits that the fields can carry.
    localparam int PW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
    // Word offsets need one bit more than the address so that they can hold the size.
    localparam int OW = ADDR_WIDTH + 1;
    localparam logic [FIELD_W-1:0] MAX_WORDS = FIELD_W'(1) << ADDR_WIDTH;

    // Configuration registers.
    logic [FIELD_W-1:0]  base_address_reg;
    logic [REGION_W-1:0] region_words_reg;

    // Sequencer state.
    phase_t         phase_reg, phase_next;
    logic [OW-1:0]  walk_offset_reg, walk_offset_next;
    logic [OW-1:0]  victim_offset_reg, victim_offset_next;
    logic [PW-1:0]  pattern_reg, pattern_next;
    logic [PW-1:0]  expected_reg, expected_next;

    // Completion of a test, decided by the next state logic.
    logic           fin_done;
    logic           fin_pass;
    logic [OW-1:0]  fin_offset;

    // Result register.
    logic                m_valid_reg;
    logic [1:0]          kind_reg, kind_next;
    logic [FIELD_W-1:0]  address_reg, address_next;
    logic [FIELD_W-1:0]  wdata_reg, wdata_next;
    logic                passed_reg, passed_next;
    logic [FIELD_W-1:0]  fail_reg, fail_next;

    logic           in_fire;
    logic [FIELD_W-1:0] region_ext;
    logic [FIELD_W-1:0] words_lim;
    logic [OW-1:0]  words;
    logic [OW-1:0]  amask;
    logic [OW-1:0]  walk_shl;
    logic [OW-1:0]  victim_shl;
    logic [OW-1:0]  walk_inc;
    logic [PW-1:0]  pattern_shl;
    logic [PW-1:0]  pattern_inc;
    logic [PW-1:0]  expected_inc;
    logic [PW-1:0]  pattern_anti;
    logic [PW-1:0]  read_eff;
    logic           mismatch;
    logic [OW-1:0]  access_offset;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    // Effective region size: zero means one word, and it never exceeds the address space.
    assign region_ext = {{(FIELD_W - REGION_W){1'b0}}, region_words_reg};
    assign words_lim  = (region_ext == '0) ? FIELD_W'(1) :
                        (region_ext > MAX_WORDS) ? MAX_WORDS : region_ext;
    assign words      = words_lim[OW-1:0];
    assign amask      = words - OW'(1);

    assign walk_shl     = {walk_offset_reg[OW-2:0], 1'b0};
    assign victim_shl   = {victim_offset_reg[OW-2:0], 1'b0};
    assign walk_inc     = walk_offset_reg + OW'(1);
    assign pattern_shl  = {pattern_reg[PW-2:0], 1'b0};
    assign pattern_inc  = pattern_reg + PW'(1);
    assign expected_inc = expected_reg + PW'(1);
    assign pattern_anti = ~pattern_reg;
    assign read_eff     = s_read_data[PW-1:0];
    assign mismatch     = (read_eff != expected_reg);

    // Next state: which access comes next, and whether the test ends here.
    always_comb begin
        phase_next         = phase_reg;
        walk_offset_next   = walk_offset_reg;
        victim_offset_next = victim_offset_reg;
        pattern_next       = pattern_reg;
        expected_next      = expected_reg;
        fin_done           = 1'b0;
        fin_pass           = 1'b0;
        fin_offset         = '0;

        if (s_func == FUNC_START) begin
            walk_offset_next   = '0;
            victim_offset_next = '0;
            expected_next      = '0;
            case (s_test_mode)
                MODE_DATA_BUS: begin
                    pattern_next = PW'(1);
                    phase_next   = PH_DB_WROTE;
                end
                MODE_ADDR_BUS: begin
                    pattern_next     = AB_PATTERN[PW-1:0];
                    walk_offset_next = OW'(1);
                    phase_next       = (amask[0]) ? PH_AB_FILL : PH_AB_BASE_ANTI;
                end
                MODE_DEVICE: begin
                    // The region always holds at least one word.
                    pattern_next = PW'(1);
                    phase_next   = PH_DV_FILL;
                end
                default: begin
                    pattern_next = '0;
                    phase_next   = PH_IDLE;
                end
            endcase
        end else begin
            case (phase_reg)
                PH_DB_WROTE: begin
                    expected_next = pattern_reg;
                    phase_next    = PH_DB_READ;
                end
                PH_DB_READ: begin
                    if (mismatch) begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                    end else begin
                        pattern_next = pattern_shl;
                        if (pattern_shl == '0) begin
                            phase_next = PH_IDLE;
                            fin_done   = 1'b1;
                            fin_pass   = 1'b1;
                        end else begin
                            phase_next = PH_DB_WROTE;
                        end
                    end
                end
                PH_AB_FILL: begin
                    walk_offset_next = walk_shl;
                    phase_next = ((walk_shl & amask) != '0) ? PH_AB_FILL : PH_AB_BASE_ANTI;
                end
                PH_AB_BASE_ANTI: begin
                    walk_offset_next = OW'(1);
                    if (amask[0]) begin
                        expected_next = pattern_reg;
                        phase_next    = PH_AB_CHECK;
                    end else begin
                        phase_next = PH_AB_BASE_PAT;
                    end
                end
                PH_AB_CHECK: begin
                    if (mismatch) begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                        fin_offset = walk_offset_reg;
                    end else begin
                        walk_offset_next = walk_shl;
                        if ((walk_shl & amask) != '0) begin
                            expected_next = pattern_reg;
                            phase_next    = PH_AB_CHECK;
                        end else begin
                            phase_next = PH_AB_BASE_PAT;
                        end
                    end
                end
                PH_AB_BASE_PAT: begin
                    victim_offset_next = OW'(1);
                    if (amask[0]) begin
                        phase_next = PH_AB_VICTIM_ANTI;
                    end else begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                        fin_pass   = 1'b1;
                    end
                end
                PH_AB_VICTIM_ANTI: begin
                    walk_offset_next = OW'(1);
                    if (amask[0]) begin
                        expected_next = pattern_reg;
                        phase_next    = PH_AB_SCAN;
                    end else begin
                        phase_next = PH_AB_VICTIM_RESTORE;
                    end
                end
                PH_AB_SCAN: begin
                    // The victim word itself is expected to differ.
                    if (mismatch && (walk_offset_reg != victim_offset_reg)) begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                        fin_offset = walk_offset_reg;
                    end else begin
                        walk_offset_next = walk_shl;
                        if ((walk_shl & amask) != '0) begin
                            expected_next = pattern_reg;
                            phase_next    = PH_AB_SCAN;
                        end else begin
                            phase_next = PH_AB_VICTIM_RESTORE;
                        end
                    end
                end
                PH_AB_VICTIM_RESTORE: begin
                    victim_offset_next = victim_shl;
                    if ((victim_shl & amask) != '0) begin
                        phase_next = PH_AB_VICTIM_ANTI;
                    end else begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                        fin_pass   = 1'b1;
                    end
                end
                PH_DV_FILL: begin
                    pattern_next = pattern_inc;
                    if (walk_inc < words) begin
                        walk_offset_next = walk_inc;
                        phase_next       = PH_DV_FILL;
                    end else begin
                        walk_offset_next = '0;
                        expected_next    = PW'(1);
                        phase_next       = PH_DV_CHECK;
                    end
                end
                PH_DV_CHECK: begin
                    if (mismatch) begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                        fin_offset = walk_offset_reg;
                    end else begin
                        phase_next = PH_DV_CLEAR;
                    end
                end
                PH_DV_CLEAR: begin
                    walk_offset_next = walk_inc;
                    expected_next    = expected_inc;
                    if (walk_inc < words) begin
                        phase_next = PH_DV_CHECK;
                    end else begin
                        phase_next = PH_IDLE;
                        fin_done   = 1'b1;
                        fin_pass   = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Outputs: the issued access follows from the phase just entered.
    always_comb begin
        kind_next     = KIND_IDLE;
        access_offset = '0;
        wdata_next    = '0;
        passed_next   = 1'b0;
        fail_next     = '0;

        if (fin_done) begin
            kind_next   = KIND_DONE;
            passed_next = fin_pass;
            if (!fin_pass) begin
                fail_next = base_address_reg + {{(FIELD_W - OW){1'b0}}, fin_offset};
            end
        end else begin
            case (phase_next)
                PH_DB_WROTE: begin
                    kind_next  = KIND_WRITE;
                    wdata_next = {{(FIELD_W - PW){1'b0}}, pattern_next};
                end
                PH_AB_FILL, PH_AB_BASE_PAT, PH_AB_VICTIM_RESTORE, PH_DV_FILL: begin
                    kind_next  = KIND_WRITE;
                    wdata_next = {{(FIELD_W - PW){1'b0}}, pattern_next};
                    if (phase_next == PH_AB_VICTIM_RESTORE) begin
                        access_offset = victim_offset_next;
                    end else if (phase_next != PH_AB_BASE_PAT) begin
                        access_offset = walk_offset_next;
                    end
                end
                PH_AB_BASE_ANTI: begin
                    kind_next  = KIND_WRITE;
                    wdata_next = {{(FIELD_W - PW){1'b0}}, ~pattern_next};
                end
                PH_AB_VICTIM_ANTI: begin
                    kind_next     = KIND_WRITE;
                    wdata_next    = {{(FIELD_W - PW){1'b0}}, pattern_anti};
                    access_offset = victim_offset_next;
                end
                PH_DV_CLEAR: begin
                    kind_next     = KIND_WRITE;
                    access_offset = walk_offset_next;
                end
                PH_DB_READ: begin
                    kind_next = KIND_READ;
                end
                PH_AB_CHECK, PH_AB_SCAN, PH_DV_CHECK: begin
                    kind_next     = KIND_READ;
                    access_offset = walk_offset_next;
                end
                default: begin
                    kind_next = KIND_IDLE;
                end
            endcase
        end

        if (kind_next == KIND_WRITE || kind_next == KIND_READ) begin
            address_next = base_address_reg + {{(FIELD_W - OW){1'b0}}, access_offset};
        end else begin
            address_next = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_address_reg <= '0;
            region_words_reg <= REGION_W'(65536);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BASE_ADDRESS: base_address_reg <= cfg_wdata;
                CFG_REGION_WORDS: region_words_reg <= cfg_wdata[REGION_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            walk_offset_reg   <= '0;
            victim_offset_reg <= '0;
            pattern_reg       <= '0;
            expected_reg      <= '0;
        end else if (in_fire) begin
            phase_reg         <= phase_next;
            walk_offset_reg   <= walk_offset_next;
            victim_offset_reg <= victim_offset_next;
            pattern_reg       <= pattern_next;
            expected_reg      <= expected_next;
        end
    end

    // Result register: valid flag under reset, payload loaded with each transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            kind_reg    <= kind_next;
            address_reg <= address_next;
            wdata_reg   <= wdata_next;
            passed_reg  <= passed_next;
            fail_reg    <= fail_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_access_kind    = kind_reg;
    assign m_access_address = address_reg;
    assign m_write_data     = wdata_reg;
    assign m_test_passed    = passed_reg;
    assign m_fail_address   = fail_reg;

    // A finished test always leaves the sequencer idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && fin_done) |=> (phase_reg == PH_IDLE))
        else $error("sequencer not idle after a done result");

    // A passing done report never names a failing address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_access_kind == KIND_DONE && m_test_passed) |-> (m_fail_address == '0))
        else $error("passing result carries a fail address");

    // Only write accesses carry data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_access_kind != KIND_WRITE) |-> (m_write_data == '0))
        else $error("write data on a non-write result");

    // An empty result register never holds off the input channel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with an empty result register");

endmodule
